// ===== rtl/sfcrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensor frame check package
// Shared types, status codes, register indexes and frame helpers for the
// sensor frame check, repair and decode unit.
// ----------------------------------------------------------------------------
package sfcrd_pkg;

   localparam int FRAME_W    = 40;
   localparam int WORD_W     = 16;
   localparam int CSR_IDX_W  = 2;

   // Result status codes
   localparam logic [1:0] STATUS_CLEAN      = 2'd0;
   localparam logic [1:0] STATUS_CHK_REPAIR = 2'd1;
   localparam logic [1:0] STATUS_BIT_REPAIR = 2'd2;
   localparam logic [1:0] STATUS_FAILED     = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_MAX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HUM_MAX  = 2'd2;

   // Limit values after reset, in tenths
   localparam logic signed [WORD_W-1:0] TEMP_MIN_RESET = -16'sd400;
   localparam logic signed [WORD_W-1:0] TEMP_MAX_RESET = 16'sd800;
   localparam logic [WORD_W-1:0]        HUM_MAX_RESET  = 16'd1000;

   typedef struct packed {
      logic signed [WORD_W-1:0] temp_min;
      logic signed [WORD_W-1:0] temp_max;
      logic [WORD_W-1:0]        hum_max;
   } limits_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [5:0]               fixed_bit;
      logic [FRAME_W-1:0]       corrected_frame;
      logic signed [WORD_W-1:0] temperature_tenths;
      logic [WORD_W-1:0]        humidity_tenths;
      logic                     in_range;
   } result_type;

   // Sign-magnitude temperature word to two's complement.
   function automatic logic signed [WORD_W-1:0] decode_temp(input logic [WORD_W-1:0] word);
      logic signed [WORD_W-1:0] mag;
      mag = {1'b0, word[WORD_W-2:0]};
      return word[WORD_W-1] ? -mag : mag;
   endfunction

   // 8-bit sum of the four payload bytes.
   function automatic logic [7:0] payload_sum(input logic [FRAME_W-1:0] frame);
      logic [9:0] sum;
      sum = {2'b00, frame[39:32]} + {2'b00, frame[31:24]}
          + {2'b00, frame[23:16]} + {2'b00, frame[15:8]};
      return sum[7:0];
   endfunction

endpackage

// ===== rtl/sfcrd_eval.sv =====
// ----------------------------------------------------------------------------
// Sensor frame evaluation
// Checks one frame, tries the checksum-byte and single-bit repairs in
// parallel, and decodes the chosen frame against the configured limits.
// ----------------------------------------------------------------------------
module sfcrd_eval
   import sfcrd_pkg::*;
(
   input  logic [FRAME_W-1:0] frame,
   input  limits_type         limits,
   output result_type         result
);

   logic [WORD_W-1:0]        hum;
   logic [WORD_W-1:0]        temp_word;
   logic [7:0]               chk;
   logic [7:0]               sum;
   logic [7:0]               diff;
   logic [7:0]               delta;
   logic [7:0]               pos_match;
   logic [7:0]               neg_match;
   logic signed [WORD_W-1:0] t_orig;
   logic                     t_ok;
   logic                     h_ok;
   logic                     orig_ok;
   logic [WORD_W-1:0]        h_cand [WORD_W];
   logic signed [WORD_W-1:0] t_cand [WORD_W];
   logic [31:0]              cand_ok;
   logic [31:0]              ok_b;
   logic [31:0]              first;
   logic [4:0]               idx;
   logic [FRAME_W-1:0]       flip;
   logic [FRAME_W-1:0]       fixed;
   logic [1:0]               status;

   // Frame layout: humidity word, temperature word, checksum byte.
   assign hum       = frame[39:24];
   assign temp_word = frame[23:8];
   assign chk       = frame[7:0];
   assign sum       = payload_sum(frame);
   assign diff      = sum ^ chk;
   assign delta     = chk - sum;

   assign t_orig  = decode_temp(temp_word);
   assign t_ok    = (t_orig >= limits.temp_min) && (t_orig <= limits.temp_max);
   assign h_ok    = hum <= limits.hum_max;
   assign orig_ok = t_ok && h_ok;

   // Flipping a payload bit of weight 2^p moves the sum by +2^p when the bit
   // was clear and by -2^p when it was set; the flip mends the checksum when
   // that step equals the checksum minus the sum.
   always_comb begin
      for (int p = 0; p < 8; p++) begin
         pos_match[p] = delta == (8'b1 << p);
         neg_match[p] = delta == (8'b0 - (8'b1 << p));
      end
   end

   // A flip in the checksum byte can only succeed where the checksum repair
   // has already been taken, so only the 32 payload bits are candidates.
   always_comb begin
      for (int j = 0; j < WORD_W; j++) begin
         h_cand[j] = hum ^ (16'b1 << j);
         t_cand[j] = decode_temp(temp_word ^ (16'b1 << j));
         cand_ok[WORD_W + j] = (frame[8 + WORD_W + j] ? neg_match[j % 8] : pos_match[j % 8])
                             && (h_cand[j] <= limits.hum_max) && t_ok;
         cand_ok[j] = (frame[8 + j] ? neg_match[j % 8] : pos_match[j % 8])
                    && (t_cand[j] >= limits.temp_min) && (t_cand[j] <= limits.temp_max)
                    && h_ok;
      end
   end

   // Reorder by index from the MSB and isolate the first passing flip.
   always_comb begin
      for (int b = 0; b < 32; b++) begin
         ok_b[b] = cand_ok[31 - b];
      end
   end

   assign first = ok_b & ((~ok_b) + 32'd1);

   always_comb begin
      idx  = '0;
      flip = '0;
      for (int b = 0; b < 32; b++) begin
         if (first[b]) begin
            idx = idx | 5'(b);
         end
         flip[FRAME_W - 1 - b] = first[b];
      end
   end

   always_comb begin
      if (sum == chk) begin
         status = STATUS_CLEAN;
         fixed  = frame;
      end else if ($onehot(diff) && orig_ok) begin
         status = STATUS_CHK_REPAIR;
         fixed  = {frame[FRAME_W-1:8], sum};
      end else if (|ok_b) begin
         status = STATUS_BIT_REPAIR;
         fixed  = frame ^ flip;
      end else begin
         status = STATUS_FAILED;
         fixed  = frame;
      end
   end

   always_comb begin
      result.status             = status;
      result.fixed_bit          = (status == STATUS_BIT_REPAIR) ? {1'b0, idx} : 6'd0;
      result.corrected_frame    = fixed;
      result.temperature_tenths = decode_temp(fixed[23:8]);
      result.humidity_tenths    = fixed[39:24];
      // A repaired frame always passed the range check.
      result.in_range = ((status == STATUS_CLEAN) || (status == STATUS_FAILED)) ? orig_ok
                                                                                 : 1'b1;
   end

endmodule

// ===== rtl/sensor_frame_check_repair_decode_unit.sv =====
// ----------------------------------------------------------------------------
// Sensor frame check, repair and decode unit
// Verifies the checksum of a 40-bit humidity/temperature frame, repairs a
// checksum byte or a single flipped bit where possible, and decodes it.
// ----------------------------------------------------------------------------
// Usage
//   The req_ channel carries one 40-bit frame per beat. Each frame produces
//   exactly one beat on the rsp_ channel: status, index of the flipped bit,
//   corrected frame, decoded temperature and humidity in tenths, and the
//   in-range flag. The csr_ channel writes the three limit registers
//   (temperature minimum, temperature maximum, humidity maximum); it is
//   always ready, and writes to an unused index are dropped.
//   A request beat passes through the input register, then through the
//   evaluation logic into the response register. A new frame is taken every
//   cycle while the receiver keeps up; the rate is set by the single
//   evaluation pass, which checks all 32 payload-bit flips at once.
//   When the receiver stalls, the response register holds its beat and the
//   input register keeps one more frame; req_ready falls only when both are
//   full. Reset empties both registers and restores the limits to
//   -40.0 and 80.0 degrees and 100.0 percent. Limits should be changed only
//   while no frame is in flight.
// ----------------------------------------------------------------------------
module sensor_frame_check_repair_decode_unit
   import sfcrd_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [FRAME_W-1:0]          req_frame,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [5:0]                  rsp_fixed_bit,
   output logic [FRAME_W-1:0]          rsp_corrected_frame,
   output logic signed [WORD_W-1:0]    rsp_temperature_tenths,
   output logic [WORD_W-1:0]           rsp_humidity_tenths,
   output logic                        rsp_in_range,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [WORD_W-1:0]           csr_data
);

   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic [FRAME_W-1:0] s1_frame_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   result_type         rsp_ff;
   result_type         eval_result;
   limits_type         limits_ff;
   limits_type         limits_in;
   logic               req_accept;
   logic               out_advance;
   logic               s1_move;

   // The response register can take a new beat when empty or being drained.
   assign out_advance = !rsp_valid_ff || rsp_ready;
   assign s1_move     = s1_valid_ff && out_advance;
   assign req_ready   = !s1_valid_ff || out_advance;
   assign req_accept  = req_valid && req_ready;
   assign csr_ready   = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (out_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      limits_in = limits_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TEMP_MIN: limits_in.temp_min = csr_data;
            CSR_TEMP_MAX: limits_in.temp_max = csr_data;
            CSR_HUM_MAX:  limits_in.hum_max  = csr_data;
            default:      limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         limits_ff.temp_min <= TEMP_MIN_RESET;
         limits_ff.temp_max <= TEMP_MAX_RESET;
         limits_ff.hum_max  <= HUM_MAX_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         limits_ff    <= limits_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_frame_ff <= req_frame;
      end
      if (s1_move) begin
         rsp_ff <= eval_result;
      end
   end

   sfcrd_eval u_eval (
      .frame  (s1_frame_ff),
      .limits (limits_ff),
      .result (eval_result)
   );

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_ff.status;
   assign rsp_fixed_bit          = rsp_ff.fixed_bit;
   assign rsp_corrected_frame    = rsp_ff.corrected_frame;
   assign rsp_temperature_tenths = rsp_ff.temperature_tenths;
   assign rsp_humidity_tenths    = rsp_ff.humidity_tenths;
   assign rsp_in_range           = rsp_ff.in_range;

   // A frame waiting behind a stalled response is neither lost nor altered.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_advance |=> s1_valid_ff && $stable(s1_frame_ff))
      else $error("held frame lost or changed");

   // An accepted beat always lands in the input register.
   a_s1_load: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted beat not captured");

   // Every frame that is not reported as failed leaves with a good checksum.
   a_chk_good: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status != STATUS_FAILED)
         |-> payload_sum(rsp_ff.corrected_frame) == rsp_ff.corrected_frame[7:0])
      else $error("corrected frame fails its checksum");

   // Repaired frames are always in range.
   a_repair_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ((rsp_ff.status == STATUS_CHK_REPAIR) ||
                       (rsp_ff.status == STATUS_BIT_REPAIR)) |-> rsp_ff.in_range)
      else $error("repaired frame out of range");

   // The flipped-bit index is only reported for a single-bit repair.
   a_fixed_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status != STATUS_BIT_REPAIR) |-> rsp_ff.fixed_bit == 6'd0)
      else $error("bit index set without a bit repair");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the sensor frame check, repair and decode unit
// Drives 40-bit frames into the request channel, predicts the status, repair
// and decoded values of every accepted frame, and compares each response
// beat with the oldest prediction. The limit registers are changed between
// phases while nothing is in flight, and both channels stall at random.
// ----------------------------------------------------------------------------
module tb
   import sfcrd_pkg::*;
();

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 5;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int RUN_LIMIT    = 8_000_000;
   localparam int MAX_REPORTS  = 100;

   // Index with no register behind it.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // Keeps its own copy of the limits and a queue of predicted responses,
   // one per accepted request beat.
   class frame_scoreboard;
      result_type               pending_results[$];
      logic signed [WORD_W-1:0] temp_min;
      logic signed [WORD_W-1:0] temp_max;
      logic [WORD_W-1:0]        hum_max;
      int                       errors;
      int                       reports;
      int                       status_seen[4];

      function new();
         temp_min = TEMP_MIN_RESET;
         temp_max = TEMP_MAX_RESET;
         hum_max  = HUM_MAX_RESET;
      endfunction

      function void write_limit(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
         case (idx)
            CSR_TEMP_MIN: temp_min = data;
            CSR_TEMP_MAX: temp_max = data;
            CSR_HUM_MAX:  hum_max  = data;
            default: ;
         endcase
      endfunction

      function logic [7:0] frame_sum(logic [FRAME_W-1:0] f);
         frame_sum = f[39:32] + f[31:24] + f[23:16] + f[15:8];
      endfunction

      // Decodes humidity and the sign-magnitude temperature, and tells
      // whether both lie inside the current limits.
      function bit decode_frame(input logic [FRAME_W-1:0] f, output int temp, output int hum);
         temp = f[23] ? -int'(f[22:8]) : int'(f[22:8]);
         hum  = int'(f[39:24]);
         return temp >= int'(temp_min) && temp <= int'(temp_max) && hum <= int'(hum_max);
      endfunction

      function bit frame_passes(logic [FRAME_W-1:0] f);
         int t;
         int h;
         return frame_sum(f) == f[7:0] && decode_frame(f, t, h);
      endfunction

      function result_type predict_repair(logic [FRAME_W-1:0] f);
         result_type         r;
         logic [7:0]         sum;
         logic [7:0]         diff;
         logic [FRAME_W-1:0] cand;
         int                 t;
         int                 h;
         r.status          = STATUS_FAILED;
         r.fixed_bit       = '0;
         r.corrected_frame = f;
         sum  = frame_sum(f);
         diff = sum ^ f[7:0];
         if (diff == 8'd0) begin
            r.status = STATUS_CLEAN;
         end else if ((diff & (diff - 8'd1)) == 8'd0 && decode_frame(f, t, h)) begin
            r.status          = STATUS_CHK_REPAIR;
            r.corrected_frame = {f[39:8], sum};
         end else begin
            for (int b = 0; b < FRAME_W && r.status == STATUS_FAILED; b++) begin
               cand = f ^ (40'd1 << (39 - b));
               if (frame_passes(cand)) begin
                  r.status          = STATUS_BIT_REPAIR;
                  r.fixed_bit       = 6'(b);
                  r.corrected_frame = cand;
               end
            end
         end
         r.in_range           = decode_frame(r.corrected_frame, t, h);
         r.temperature_tenths = 16'(t);
         r.humidity_tenths    = 16'(h);
         return r;
      endfunction

      function void note_frame(logic [FRAME_W-1:0] f);
         pending_results.push_back(predict_repair(f));
      endfunction

      function bit field_matches(string name, logic [63:0] e, logic [63:0] a);
         if (a === e) return 1'b1;
         if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
         end
         return 1'b0;
      endfunction

      function void check_result(result_type act);
         result_type exp;
         bit         ok;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: response beat with nothing outstanding, status %0h", $time,
                     act.status);
            return;
         end
         exp = pending_results.pop_front();
         ok  = field_matches("status", exp.status, act.status);
         ok &= field_matches("fixed_bit", exp.fixed_bit, act.fixed_bit);
         ok &= field_matches("corrected_frame", exp.corrected_frame, act.corrected_frame);
         ok &= field_matches("temperature_tenths", exp.temperature_tenths,
                             act.temperature_tenths);
         ok &= field_matches("humidity_tenths", exp.humidity_tenths, act.humidity_tenths);
         ok &= field_matches("in_range", exp.in_range, act.in_range);
         if (!ok) errors++;
         status_seen[exp.status]++;
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [FRAME_W-1:0]       req_frame = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [1:0]               rsp_status;
   logic [5:0]               rsp_fixed_bit;
   logic [FRAME_W-1:0]       rsp_corrected_frame;
   logic signed [WORD_W-1:0] rsp_temperature_tenths;
   logic [WORD_W-1:0]        rsp_humidity_tenths;
   logic                     rsp_in_range;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [WORD_W-1:0]        csr_data = '0;

   frame_scoreboard sb;

   // Shared between the stimulus and the response process: no_idle removes
   // random gaps on both sides, hold_req asks for one long response stall.
   bit hold_req;
   bit no_idle;
   int frames_sent;
   int settings_used;

   always #HALF_PERIOD clock = ~clock;

   sensor_frame_check_repair_decode_unit dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_frame              (req_frame),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_status             (rsp_status),
      .rsp_fixed_bit          (rsp_fixed_bit),
      .rsp_corrected_frame    (rsp_corrected_frame),
      .rsp_temperature_tenths (rsp_temperature_tenths),
      .rsp_humidity_tenths    (rsp_humidity_tenths),
      .rsp_in_range           (rsp_in_range),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [WORD_W-1:0] encode_temp(int t);
      return (t < 0) ? {1'b1, 15'(-t)} : {1'b0, 15'(t)};
   endfunction

   // Builds a frame whose checksum byte is correct.
   function automatic logic [FRAME_W-1:0] make_frame(logic [15:0] h, logic [15:0] tw);
      logic [7:0] s;
      s = h[15:8] + h[7:0] + tw[15:8] + tw[7:0];
      return {h, tw, s};
   endfunction

   // Most frames start as well-formed readings inside the current limits,
   // then get zero, one or two bits corrupted; the rest is plain noise.
   function automatic logic [FRAME_W-1:0] random_frame();
      int                 t;
      int                 h;
      int                 sel;
      int                 b1;
      int                 b2;
      logic [15:0]        tw;
      logic [FRAME_W-1:0] f;
      if (sb.temp_min <= sb.temp_max && $urandom_range(0, 99) < 60) begin
         t  = int'(sb.temp_min)
            + int'($urandom_range(0, int'(sb.temp_max) - int'(sb.temp_min)));
         h  = $urandom_range(0, int'(sb.hum_max));
         tw = (t == 0 && $urandom_range(0, 1) == 1) ? 16'h8000 : encode_temp(t);
      end else begin
         h  = $urandom_range(0, 65535);
         tw = 16'($urandom);
      end
      f   = make_frame(16'(h), tw);
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         // left clean
      end else if (sel < 55) begin
         f = f ^ (40'd1 << $urandom_range(0, 39));
      end else if (sel < 65) begin
         f = f ^ (40'd1 << $urandom_range(0, 7));
      end else if (sel < 80) begin
         b1 = $urandom_range(0, 39);
         b2 = (b1 + $urandom_range(1, 39)) % 40;
         f  = f ^ (40'd1 << b1) ^ (40'd1 << b2);
      end else begin
         f = {8'($urandom), 32'($urandom)};
      end
      return f;
   endfunction

   // Offers one frame and holds it until the beat is taken. The valid line
   // is only lowered when a gap follows, so back-to-back beats keep it high.
   task automatic send_frame(logic [FRAME_W-1:0] f);
      int gap;
      req_valid <= 1'b1;
      req_frame <= f;
      do @(posedge clock); while (!req_ready);
      sb.note_frame(f);
      frames_sent++;
      gap = no_idle ? 0 : gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Leaves csr_valid high so that a following write can run straight on;
   // the caller lowers it after the last write.
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_limit(idx, data);
   endtask

   task automatic apply_limits(int tmin, int tmax, int hmax);
      write_register(CSR_TEMP_MIN, 16'(tmin));
      write_register(CSR_TEMP_MAX, 16'(tmax));
      write_register(CSR_HUM_MAX, 16'(hmax));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Waits for every outstanding response, then for a quiet stretch so that
   // nothing is left in the pipeline before the limits change.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(int count);
      repeat (count) send_frame(random_frame());
   endtask

   // Hand-picked frames under the reset limits: extremes, every status,
   // the negative zero word, values on and just past each limit, checksum
   // faults of one and two bits, and payload flips at both ends.
   task automatic run_directed();
      logic [FRAME_W-1:0] frames[$];
      logic [FRAME_W-1:0] good;
      good = make_frame(16'd650, 16'h00FD);
      frames.push_back(40'h00_0000_0000);
      frames.push_back(40'hFF_FFFF_FFFF);
      frames.push_back(good);
      frames.push_back(make_frame(16'd455, encode_temp(-100)));
      frames.push_back(make_frame(16'd0, 16'h8000));
      frames.push_back(make_frame(16'd1000, encode_temp(800)));
      frames.push_back(make_frame(16'd0, encode_temp(-400)));
      frames.push_back(make_frame(16'd1001, encode_temp(200)));
      frames.push_back(make_frame(16'd500, encode_temp(801)));
      frames.push_back(make_frame(16'd500, encode_temp(-401)));
      frames.push_back(make_frame(16'hFFFF, 16'h7FFF));
      frames.push_back(make_frame(16'hFFFF, 16'hFFFF));
      frames.push_back(good ^ 40'h01);
      frames.push_back(good ^ 40'h80);
      frames.push_back(make_frame(16'd2000, encode_temp(100)) ^ 40'h04);
      frames.push_back(good ^ (40'd1 << 39));
      frames.push_back(good ^ (40'd1 << 8));
      frames.push_back(good ^ 40'h03);
      frames.push_back(good ^ 40'h00_0100_0001);
      frames.push_back(40'h80_0000_0000);
      foreach (frames[i]) send_frame(frames[i]);
   endtask

   // Response side: checks every accepted beat and varies rsp_ready. A
   // requested hold keeps ready low long enough that the unit fills up and
   // pushes back on the request channel.
   initial begin
      result_type seen_beat;
      int         stall_left;
      stall_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            seen_beat.status             = rsp_status;
            seen_beat.fixed_bit          = rsp_fixed_bit;
            seen_beat.corrected_frame    = rsp_corrected_frame;
            seen_beat.temperature_tenths = rsp_temperature_tenths;
            seen_beat.humidity_tenths    = rsp_humidity_tenths;
            seen_beat.in_range           = rsp_in_range;
            sb.check_result(seen_beat);
         end
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req   = 1'b0;
            stall_left = 0;
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0) stall_left = gap_len();
         end
      end
   end

   // Main sequence: reset once, then phases under different limit settings.
   initial begin
      int tmin;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset limits first, with the hand-picked frames and some random ones.
      run_directed();
      run_random(280);
      drain();

      // Widest limits with no gaps on either side.
      apply_limits(-32767, 32767, 65535);
      no_idle = 1'b1;
      run_random(200);
      drain();
      no_idle = 1'b0;

      // Everything pinned to zero.
      apply_limits(0, 0, 0);
      run_random(150);
      drain();

      // Crossed temperature limits: no temperature can be in range.
      apply_limits(100, -100, 500);
      run_random(100);
      drain();

      // A write to the spare index must be dropped; the limit writes run
      // straight on behind it. The receiver then holds off for a long
      // stretch while frames keep coming.
      write_register(CSR_SPARE, 16'hFFFF);
      apply_limits(-400, 800, 1000);
      hold_req = 1'b1;
      no_idle  = 1'b1;
      run_random(300);
      no_idle = 1'b0;
      drain();

      // A handful of random limit settings.
      repeat (4) begin
         tmin = int'($urandom_range(0, 2000)) - 1000;
         apply_limits(tmin, tmin + int'($urandom_range(0, 2000)),
                      int'($urandom_range(0, 65535)));
         run_random(90);
         drain();
      end

      $display("tb: %0d frames checked under %0d limit settings, with stalls on both sides",
               frames_sent, settings_used);
      $display("tb: outcomes seen: clean %0d, checksum repaired %0d, bit repaired %0d, failed %0d",
               sb.status_seen[STATUS_CLEAN], sb.status_seen[STATUS_CHK_REPAIR],
               sb.status_seen[STATUS_BIT_REPAIR], sb.status_seen[STATUS_FAILED]);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #RUN_LIMIT;
      $display("tb: FAIL");
      $finish;
   end

endmodule
